### hdl/kmeans_lloyd_iteration_core_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef KMEANS_LLOYD_ITERATION_CORE_DEFINES_SVH
`define KMEANS_LLOYD_ITERATION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KML_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kml check failed");

// The consequent must hold in the cycle after the antecedent.
`define KML_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kml check failed");

`endif

### hdl/kml_pkg.sv
package kml_pkg;

	localparam int COORD_BITS   = 24;
	localparam int COUNT_BITS   = 20;
	localparam int SUM_BITS     = COORD_BITS + COUNT_BITS;
	localparam int DIST_BITS    = 2 * COORD_BITS + 2;
	localparam int IDX_BITS     = 8;
	localparam int DEF_CLUSTERS = 16;
	localparam int DEF_TOL      = 10;
	localparam int DEF_PASSES   = 10;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_POINT = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic RES_ASSIGN = 1'b0;
	localparam logic RES_CENTER = 1'b1;

	localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
	localparam logic [1:0] REG_COUNT_TOL    = 2'd1;
	localparam logic [1:0] REG_MAX_PASSES   = 2'd2;

	typedef struct packed {
		logic [1:0]                   kind;
		logic [3:0]                   slot;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
	} item_t;

	typedef struct packed {
		logic                         result_kind;
		logic [3:0]                   cluster;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic [COUNT_BITS-1:0]        member_count;
		logic                         converged;
		logic                         last;
	} result_t;

	// Search token that walks down the cell row.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic                         has_best;
		logic [DIST_BITS-1:0]         best_d;
		logic [IDX_BITS-1:0]          best_idx;
		logic                         cand_valid;
		logic [DIST_BITS-1:0]         cand_d;
		logic [IDX_BITS-1:0]          cand_idx;
	} tok_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COUNT_BITS-1:0]        count;
	} rep_t;

	typedef struct packed {
		logic load;
		logic update;
		logic div_start;
		logic commit;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic                  unsettled;
		logic [COUNT_BITS-1:0] hit_count;
	} cell_stat_t;

	// Folds the pending candidate into the running best. A strict compare keeps
	// the lower index on a tie, since lower cells come first.
	function automatic tok_t merge_best(input tok_t t);
		tok_t r;
		r = t;
		if (t.cand_valid && (!t.has_best || (t.cand_d < t.best_d))) begin
			r.has_best = 1'b1;
			r.best_d   = t.cand_d;
			r.best_idx = t.cand_idx;
		end
		r.cand_valid = 1'b0;
		return r;
	endfunction

endpackage

### hdl/kml_div.sv
module kml_div #(
	parameter int N = 44,
	parameter int D = 20
) (
	input  logic         clk,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic [N-1:0] quotient
);

	logic [N-1:0] quo_q;
	logic [D-1:0] rem_q;
	logic [D-1:0] div_q;
	logic [D:0]   trial;
	logic [D:0]   diff;
	logic         ge;

	// Restoring division over N steps, one quotient bit per cycle.
	always_comb begin
		trial = {rem_q, quo_q[N-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else begin
			quo_q <= {quo_q[N-2:0], ge};
			rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
		end
	end

	assign quotient = quo_q;

endmodule

### hdl/kml_cell.sv
module kml_cell #(
	parameter int INDEX = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  kml_pkg::cell_ctl_t                     ctl,
	input  logic                                   en,
	input  logic [kml_pkg::IDX_BITS-1:0]           sel_idx,
	input  logic signed [kml_pkg::COORD_BITS-1:0]  dat_x,
	input  logic signed [kml_pkg::COORD_BITS-1:0]  dat_y,
	input  logic [kml_pkg::COUNT_BITS-1:0]         tol,
	input  logic                                   tok_in_valid,
	input  kml_pkg::tok_t                          tok_in,
	output logic                                   tok_out_valid,
	output kml_pkg::tok_t                          tok_out,
	input  kml_pkg::rep_t                          rep_in,
	output kml_pkg::rep_t                          rep_out,
	output kml_pkg::cell_stat_t                    stat
);

	localparam int C = kml_pkg::COORD_BITS;
	localparam int S = kml_pkg::SUM_BITS;
	localparam int K = kml_pkg::COUNT_BITS;

	logic signed [C-1:0] cen_x_q, cen_y_q;
	logic signed [S-1:0] sum_x_q, sum_y_q;
	logic [K-1:0]        cnt_q, prior_q;
	kml_pkg::rep_t       rep_q;

	logic                hit;
	logic                sat;
	logic signed [C:0]   dx, dy;
	logic [C:0]          ax, ay;
	logic [2*C+1:0]      sq_x, sq_y;
	kml_pkg::tok_t       tok_nx;
	logic [S-1:0]        mag_x, mag_y, dvd_x, dvd_y, quo_x, quo_y;
	logic [C-1:0]        q_x, q_y;
	logic signed [C-1:0] mean_x, mean_y;
	logic [K-1:0]        cdiff;

	assign hit = (sel_idx == kml_pkg::IDX_BITS'(INDEX));
	assign sat = (cnt_q == '1);

	// Squared distance of the passing point to this centroid; the previous cell's
	// candidate is folded in alongside.
	always_comb begin
		dx   = {tok_in.px[C-1], tok_in.px} - {cen_x_q[C-1], cen_x_q};
		dy   = {tok_in.py[C-1], tok_in.py} - {cen_y_q[C-1], cen_y_q};
		ax   = dx[C] ? -dx : dx;
		ay   = dy[C] ? -dy : dy;
		sq_x = ax * ax;
		sq_y = ay * ay;
		tok_nx            = kml_pkg::merge_best(tok_in);
		tok_nx.cand_valid = en;
		tok_nx.cand_d     = sq_x + sq_y;
		tok_nx.cand_idx   = kml_pkg::IDX_BITS'(INDEX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_valid <= 1'b0;
		end else begin
			tok_out_valid <= tok_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_out <= tok_nx;
	end

	// Rounded mean: magnitude plus half the count, divided, sign restored.
	always_comb begin
		mag_x  = sum_x_q[S-1] ? -sum_x_q : sum_x_q;
		mag_y  = sum_y_q[S-1] ? -sum_y_q : sum_y_q;
		dvd_x  = mag_x + S'(cnt_q >> 1);
		dvd_y  = mag_y + S'(cnt_q >> 1);
		q_x    = quo_x[C-1:0];
		q_y    = quo_y[C-1:0];
		mean_x = sum_x_q[S-1] ? -q_x : q_x;
		mean_y = sum_y_q[S-1] ? -q_y : q_y;
	end

	kml_div #(.N(S), .D(K)) u_div_x (
		.clk(clk), .start(ctl.div_start), .dividend(dvd_x), .divisor(cnt_q),
		.quotient(quo_x)
	);

	kml_div #(.N(S), .D(K)) u_div_y (
		.clk(clk), .start(ctl.div_start), .dividend(dvd_y), .divisor(cnt_q),
		.quotient(quo_y)
	);

	always_ff @(posedge clk) begin
		if (ctl.load && hit) begin
			cen_x_q <= dat_x;
			cen_y_q <= dat_y;
		end else if (ctl.commit && en && (cnt_q != '0)) begin
			cen_x_q <= mean_x;
			cen_y_q <= mean_y;
		end
		if (ctl.commit) begin
			rep_q.x     <= (cnt_q != '0) ? mean_x : cen_x_q;
			rep_q.y     <= (cnt_q != '0) ? mean_y : cen_y_q;
			rep_q.count <= cnt_q;
		end else if (ctl.shift) begin
			rep_q <= rep_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
			prior_q <= '0;
		end else if (ctl.commit) begin
			prior_q <= cnt_q;
			cnt_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (ctl.update && hit && !sat) begin
			cnt_q   <= cnt_q + K'(1);
			sum_x_q <= sum_x_q + {{(S-C){dat_x[C-1]}}, dat_x};
			sum_y_q <= sum_y_q + {{(S-C){dat_y[C-1]}}, dat_y};
		end
	end

	always_comb begin
		cdiff          = (cnt_q >= prior_q) ? (cnt_q - prior_q) : (prior_q - cnt_q);
		stat.unsettled = en && (cdiff > tol);
		stat.hit_count = (ctl.update && hit) ? (sat ? cnt_q : cnt_q + K'(1)) : '0;
	end

	assign rep_out = rep_q;

endmodule

### hdl/kmeans_lloyd_iteration_core.sv
// Two-dimensional k-means engine for one Lloyd pass at a time, in signed Q9.14.
// Items are taken on start while busy is low; results come out one per cycle,
// each flagged by a single-cycle result_valid strobe, and the receiver cannot
// stall them, so it must take every beat as it appears. A load item gives no
// result. A point item keeps busy high while it walks the row of cells, one
// cell per cycle, and then updates its cluster; its one result appears in the
// first cycle with busy low again. An end-of-pass item keeps busy high while
// the bit-serial mean dividers in every cell run, then while the reports of
// the clusters in use shift out of the row, one per cycle; the last report
// carries last and the converged flag. A kind of three is dropped.
// Configuration writes are always ready and must be made only while the block
// is idle. Reading a centroid never loaded gives no defined answer.
module kmeans_lloyd_iteration_core #(
	parameter int MAX_CLUSTERS = kml_pkg::DEF_CLUSTERS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  kml_pkg::item_t                item,
	output logic                          result_valid,
	output kml_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [kml_pkg::COUNT_BITS-1:0] cfg_data
);

	localparam int IW  = $clog2(MAX_CLUSTERS);
	localparam int KW  = $clog2(MAX_CLUSTERS + 1);
	localparam int CW  = (KW > 5) ? KW : 5;
	localparam int SW  = (KW > 4) ? KW : 4;
	localparam int DN  = kml_pkg::SUM_BITS;
	localparam int DCW = $clog2(DN + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEARCH, ST_UPDATE, ST_DIVIDE, ST_REPORT
	} state_t;

	state_t                           state_q;
	logic [4:0]                       nclus_q;
	logic [kml_pkg::COUNT_BITS-1:0]   tol_q;
	logic [7:0]                       maxp_q;
	logic [7:0]                       passes_q;
	logic                             done_q;
	logic [IW-1:0]                    best_q;
	logic [IW-1:0]                    rep_idx_q;
	logic [DCW-1:0]                   div_cnt_q;
	kml_pkg::item_t                   item_q;

	logic                             accept;
	logic [CW-1:0]                    nc_ext;
	logic [KW-1:0]                    k;
	logic                             slot_ok;
	logic [7:0]                       passes_nx;
	kml_pkg::cell_ctl_t               ctl;
	logic [kml_pkg::IDX_BITS-1:0]     sel_idx;
	logic signed [kml_pkg::COORD_BITS-1:0] dat_x, dat_y;
	logic [MAX_CLUSTERS-1:0]          en;
	logic [MAX_CLUSTERS:0]            tok_v;
	kml_pkg::tok_t                    tok [MAX_CLUSTERS+1];
	kml_pkg::rep_t                    rep [MAX_CLUSTERS+1];
	kml_pkg::cell_stat_t              stat [MAX_CLUSTERS];
	kml_pkg::tok_t                    fin;
	logic [kml_pkg::COUNT_BITS-1:0]   hit_or;
	logic                             unsettled;
	logic                             rep_last;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Clusters in use: the register clamped to one at least and the row length
	// at most.
	always_comb begin
		nc_ext = CW'(nclus_q);
		if (nclus_q == 5'd0) begin
			k = KW'(1);
		end else if (nc_ext > CW'(MAX_CLUSTERS)) begin
			k = KW'(MAX_CLUSTERS);
		end else begin
			k = KW'(nc_ext);
		end
	end

	assign slot_ok   = SW'(item.slot) < SW'(MAX_CLUSTERS);
	assign passes_nx = (passes_q == 8'hFF) ? passes_q : passes_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nclus_q <= 5'(kml_pkg::DEF_CLUSTERS);
			tol_q   <= kml_pkg::COUNT_BITS'(kml_pkg::DEF_TOL);
			maxp_q  <= 8'(kml_pkg::DEF_PASSES);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kml_pkg::REG_NUM_CLUSTERS: nclus_q <= cfg_data[4:0];
				kml_pkg::REG_COUNT_TOL:    tol_q   <= cfg_data;
				kml_pkg::REG_MAX_PASSES:   maxp_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Broadcast controls to the row. Loads take the slot straight from the
	// input beat; updates use the winner found by the search.
	always_comb begin
		ctl.load      = accept && (item.kind == kml_pkg::KIND_LOAD) && slot_ok;
		ctl.update    = (state_q == ST_UPDATE);
		ctl.div_start = accept && (item.kind == kml_pkg::KIND_END);
		ctl.commit    = (state_q == ST_DIVIDE) && (div_cnt_q == DCW'(DN));
		ctl.shift     = (state_q == ST_REPORT);
		sel_idx       = (state_q == ST_IDLE) ? kml_pkg::IDX_BITS'(item.slot)
		                                     : kml_pkg::IDX_BITS'(best_q);
		dat_x         = (state_q == ST_IDLE) ? item.coord_x : item_q.coord_x;
		dat_y         = (state_q == ST_IDLE) ? item.coord_y : item_q.coord_y;
	end

	// The search token enters the first cell on the accepting edge.
	always_comb begin
		tok_v[0]          = accept && (item.kind == kml_pkg::KIND_POINT);
		tok[0].px         = item.coord_x;
		tok[0].py         = item.coord_y;
		tok[0].has_best   = 1'b0;
		tok[0].best_d     = '0;
		tok[0].best_idx   = '0;
		tok[0].cand_valid = 1'b0;
		tok[0].cand_d     = '0;
		tok[0].cand_idx   = '0;
		rep[MAX_CLUSTERS] = '0;
	end

	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		assign en[i] = KW'(i) < k;
		kml_cell #(.INDEX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .en(en[i]), .sel_idx(sel_idx),
			.dat_x(dat_x), .dat_y(dat_y), .tol(tol_q),
			.tok_in_valid(tok_v[i]), .tok_in(tok[i]),
			.tok_out_valid(tok_v[i+1]), .tok_out(tok[i+1]),
			.rep_in(rep[i+1]), .rep_out(rep[i]), .stat(stat[i])
		);
	end

	always_comb begin
		fin       = kml_pkg::merge_best(tok[MAX_CLUSTERS]);
		hit_or    = '0;
		unsettled = 1'b0;
		for (int i = 0; i < MAX_CLUSTERS; i++) begin
			hit_or    = hit_or | stat[i].hit_count;
			unsettled = unsettled | stat[i].unsettled;
		end
		rep_last = (KW'(rep_idx_q) + KW'(1)) == k;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			passes_q     <= '0;
			done_q       <= 1'b0;
			best_q       <= '0;
			rep_idx_q    <= '0;
			div_cnt_q    <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.kind == kml_pkg::KIND_POINT)) begin
						state_q <= ST_SEARCH;
					end else if (accept && (item.kind == kml_pkg::KIND_END)) begin
						passes_q  <= passes_nx;
						done_q    <= !unsettled || (passes_nx >= maxp_q);
						div_cnt_q <= '0;
						state_q   <= ST_DIVIDE;
					end
				end
				ST_SEARCH: begin
					if (tok_v[MAX_CLUSTERS]) begin
						best_q  <= IW'(fin.best_idx);
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					result_valid        <= 1'b1;
					result.result_kind  <= kml_pkg::RES_ASSIGN;
					result.cluster      <= 4'(best_q);
					result.center_x     <= '0;
					result.center_y     <= '0;
					result.member_count <= hit_or;
					result.converged    <= 1'b0;
					result.last         <= 1'b0;
					state_q             <= ST_IDLE;
				end
				ST_DIVIDE: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (ctl.commit) begin
						rep_idx_q <= '0;
						state_q   <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					result_valid        <= 1'b1;
					result.result_kind  <= kml_pkg::RES_CENTER;
					result.cluster      <= 4'(rep_idx_q);
					result.center_x     <= rep[0].x;
					result.center_y     <= rep[0].y;
					result.member_count <= rep[0].count;
					result.converged    <= rep_last && done_q;
					result.last         <= rep_last;
					rep_idx_q           <= rep_idx_q + IW'(1);
					if (rep_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/kml_checker.sv
`include "kmeans_lloyd_iteration_core_defines.svh"

module kml_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input kml_pkg::item_t                 item,
	input logic                           result_valid,
	input kml_pkg::result_t               result
);

	`KML_ASSERT_NEXT(a_point_busy, start && !busy && (item.kind == kml_pkg::KIND_POINT), busy)
	`KML_ASSERT_NOW(a_conv_last, result_valid && result.converged, result.last)
	`KML_ASSERT_NOW(a_last_center, result_valid && result.last, result.result_kind == kml_pkg::RES_CENTER)
	`KML_ASSERT_NOW(a_assign_clean, result_valid && (result.result_kind == kml_pkg::RES_ASSIGN), (result.center_x == '0) && (result.center_y == '0) && !result.last)

endmodule

bind kmeans_lloyd_iteration_core kml_checker u_kml_checker (.*);
